### hw/rtl/gradient_colormap_lookup_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gradient colormap lookup
// Shared property wrappers with clock, reset and message arguments.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_COLORMAP_LOOKUP_DEFINES_SVH
`define GRADIENT_COLORMAP_LOOKUP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GCL_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GCL_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gcl_pkg.sv
// ---------------------------------------------------------------------------
// gcl_pkg
// Widths, stop layout, register indexes and pipeline stage map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcl_pkg;

    localparam int POS_W     = 16;
    localparam int IN_POS_W  = POS_W + 2;
    localparam int GAIN_W    = 10;
    localparam int GAIN_FRAC = 8;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int CH_ALPHA  = 0;

    localparam int CFG_W     = POS_W + NUM_CH * CH_W;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 3;

    localparam int MAX_STOPS     = 4;
    localparam int NUM_STOP_REGS = 4;
    localparam int EFF_STOPS     = (MAX_STOPS < NUM_STOP_REGS) ? MAX_STOPS : NUM_STOP_REGS;
    localparam int NUM_SEG       = EFF_STOPS - 1;

    localparam int DIFF_W = POS_W + 1;
    localparam int D_W    = POS_W + 2;
    localparam int DEN_W  = POS_W + 1;
    localparam int DC_W   = CH_W + 1;
    localparam int NUM_W  = POS_W + CH_W + 2;
    localparam int MAG_W  = NUM_W - 1;
    localparam int PROD_W = GAIN_W + MAG_W;
    localparam int N_W    = PROD_W - GAIN_FRAC;
    localparam int QUO_W  = CH_W;
    localparam int REM_W  = DEN_W + QUO_W;
    localparam int DIV_STEPS = QUO_W;

    localparam int S_IN   = 0;
    localparam int S_SEG  = 1;
    localparam int S_SEL  = 2;
    localparam int S_MUL  = 3;
    localparam int S_NUM  = 4;
    localparam int S_GAIN = 5;
    localparam int S_DIV  = 6;
    localparam int S_OUT  = S_DIV + DIV_STEPS + 1;
    localparam int NSTAGE = S_OUT + 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [CH_W-1:0]  CH_MAX  = {CH_W{1'b1}};
    localparam logic signed [D_W-1:0] UNIT_D = {2'b01, {POS_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THREE = 3'd4;

    localparam logic [CNT_W-1:0] STOP_COUNT_RESET = 3'd4;
    localparam logic [CFG_W-1:0] STOP_RESET [NUM_STOP_REGS] = '{
        48'd65535,
        48'd84360050475263,
        48'd168716816122111,
        48'd281474976710655
    };

    // color[3] red, [2] green, [1] blue, [0] alpha
    typedef struct packed {
        logic [POS_W-1:0]             pos;
        logic [NUM_CH-1:0][CH_W-1:0]  color;
    } stop_t;

endpackage

### hw/rtl/gcl_ifs.sv
// ---------------------------------------------------------------------------
// gcl stream interfaces
// Pixel request channel and color result channel, valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcl_pixel_if;
    import gcl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [IN_POS_W-1:0] position;
    logic [GAIN_W-1:0]          luminance;
    logic [GAIN_W-1:0]          opacity_gain;

    modport source (output valid, output position, output luminance,
                    output opacity_gain, input ready);
    modport sink   (input valid, input position, input luminance,
                    input opacity_gain, output ready);
endinterface

interface gcl_color_if;
    import gcl_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_out;

    modport source (output valid, output red, output green, output blue,
                    output alpha_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_out, output ready);
endinterface

### hw/rtl/gradient_colormap_lookup.sv
// Throughput: one pixel per clock; every stage moves on its own, so only a
// stalled color output holds the pipe, and bubbles are closed up behind it.
// The quotient unit takes eight compare/subtract steps, one per stage.
// Reset: valid bits cleared, stop count 4 and the default stop table loaded.
// ---------------------------------------------------------------------------
// gradient_colormap_lookup
// Piecewise linear color map with RGB and alpha gains, 16-stage pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_colormap_lookup_defines.svh"

module gradient_colormap_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gcl_pkg::CFG_W-1:0]     cfg_data,
    gcl_pixel_if.sink                     pixel,
    gcl_color_if.source                   color
);
    import gcl_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [GAIN_W-1:0] lum;
        logic [GAIN_W-1:0] opa;
    } in_stage_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [GAIN_W-1:0]  lum;
        logic [GAIN_W-1:0]  opa;
        logic               found;
        logic [NUM_SEG-1:0] seg;
    } seg_stage_t;

    typedef struct packed {
        logic                         found;
        logic [GAIN_W-1:0]            lum;
        logic [GAIN_W-1:0]            opa;
        logic [D_W-1:0]               d;
        logic [DIFF_W-1:0]            dp;
        logic [NUM_CH-1:0][CH_W-1:0]  c0;
        logic [NUM_CH-1:0][DC_W-1:0]  dc;
    } sel_stage_t;

    typedef struct packed {
        logic                         found;
        logic [GAIN_W-1:0]            lum;
        logic [GAIN_W-1:0]            opa;
        logic                         neg;
        logic [DEN_W-1:0]             den;
        logic [NUM_CH-1:0][NUM_W-1:0] a;
        logic [NUM_CH-1:0][NUM_W-1:0] b;
    } mul_stage_t;

    typedef struct packed {
        logic                         found;
        logic [GAIN_W-1:0]            lum;
        logic [GAIN_W-1:0]            opa;
        logic [DEN_W-1:0]             den;
        logic [NUM_CH-1:0]            pos;
        logic [NUM_CH-1:0][MAG_W-1:0] mag;
    } num_stage_t;

    typedef struct packed {
        logic                       found;
        logic [DEN_W-1:0]           den;
        logic [NUM_CH-1:0]          pos;
        logic [NUM_CH-1:0][N_W-1:0] n;
    } gain_stage_t;

    typedef struct packed {
        logic             pos;
        logic             sat;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic                        found;
        logic [DEN_W-1:0]            den;
        div_lane_t [NUM_CH-1:0]      lane;
    } div_stage_t;

    // configuration
    logic [CNT_W-1:0] stop_count_reg;
    stop_t            stop_reg [NUM_STOP_REGS];
    logic [CNT_W-1:0] cnt_eff;

    // pipeline control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   adv;

    in_stage_t   in_reg,   in_next;
    seg_stage_t  seg_reg,  seg_next;
    sel_stage_t  sel_reg,  sel_next;
    mul_stage_t  mul_reg,  mul_next;
    num_stage_t  num_reg,  num_next;
    gain_stage_t gain_reg, gain_next;
    div_stage_t  div_reg  [DIV_STEPS+1];
    div_stage_t  div_next [DIV_STEPS+1];
    logic [NUM_CH-1:0][CH_W-1:0] out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int i = 0; i < NUM_STOP_REGS; i++)
            begin
                stop_reg[i] <= stop_t'(STOP_RESET[i]);
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STOP_COUNT: stop_count_reg <= cfg_data[CNT_W-1:0];
                REG_STOP_ZERO:  stop_reg[0]    <= stop_t'(cfg_data);
                REG_STOP_ONE:   stop_reg[1]    <= stop_t'(cfg_data);
                REG_STOP_TWO:   stop_reg[2]    <= stop_t'(cfg_data);
                REG_STOP_THREE: stop_reg[3]    <= stop_t'(cfg_data);
                default: ;
            endcase
        end
    end

    assign cnt_eff = (stop_count_reg > CNT_W'(EFF_STOPS)) ? CNT_W'(EFF_STOPS) : stop_count_reg;

    // a stage takes new data when it is empty or its successor moves
    always_comb
    begin
        adv[NSTAGE] = color.ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign valid_next  = {valid_reg[NSTAGE-2:0], pixel.valid};
    assign pixel.ready = adv[S_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // clamp
    always_comb
    begin
        in_next.lum = pixel.luminance;
        in_next.opa = pixel.opacity_gain;
        if (pixel.position[IN_POS_W-1])
        begin
            in_next.pos = '0;
        end
        else if (|pixel.position[IN_POS_W-2:POS_W])
        begin
            in_next.pos = POS_MAX;
        end
        else
        begin
            in_next.pos = pixel.position[POS_W-1:0];
        end
    end

    // first segment whose upper stop is at or above the position
    always_comb
    begin
        logic [NUM_SEG-1:0] hit;
        logic               taken;
        hit   = '0;
        taken = 1'b0;
        seg_next.pos = in_reg.pos;
        seg_next.lum = in_reg.lum;
        seg_next.opa = in_reg.opa;
        seg_next.seg = '0;
        for (int i = 0; i < NUM_SEG; i++)
        begin
            hit[i] = (CNT_W'(i + 1) < cnt_eff) && (stop_reg[i + 1].pos >= in_reg.pos);
            seg_next.seg[i] = hit[i] && !taken;
            taken = taken || hit[i];
        end
        seg_next.found = taken;
    end

    // stop select and differences
    always_comb
    begin
        stop_t                    lo;
        stop_t                    hi;
        logic signed [DIFF_W-1:0] dpos;
        lo = '0;
        hi = '0;
        for (int i = 0; i < NUM_SEG; i++)
        begin
            if (seg_reg.seg[i])
            begin
                lo = stop_reg[i];
                hi = stop_reg[i + 1];
            end
        end
        dpos = $signed({1'b0, hi.pos}) - $signed({1'b0, lo.pos});
        sel_next.found = seg_reg.found;
        sel_next.lum   = seg_reg.lum;
        sel_next.opa   = seg_reg.opa;
        // zero-length segment spans a full unit
        sel_next.d     = (dpos == '0) ? UNIT_D : D_W'(dpos);
        sel_next.dp    = $signed({1'b0, seg_reg.pos}) - $signed({1'b0, lo.pos});
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sel_next.c0[ch] = lo.color[ch];
            sel_next.dc[ch] = {1'b0, hi.color[ch]} - {1'b0, lo.color[ch]};
        end
    end

    // c0 * d and (p - p0) * (c1 - c0)
    always_comb
    begin
        logic signed [D_W-1:0]   d_s;
        logic signed [D_W-1:0]   d_abs;
        logic signed [NUM_W-1:0] d_x;
        logic signed [NUM_W-1:0] dp_x;
        logic signed [NUM_W-1:0] c0_x;
        logic signed [NUM_W-1:0] dc_x;
        d_s   = $signed(sel_reg.d);
        d_abs = d_s[D_W-1] ? -d_s : d_s;
        d_x   = NUM_W'(d_s);
        dp_x  = NUM_W'($signed(sel_reg.dp));
        mul_next.found = sel_reg.found;
        mul_next.lum   = sel_reg.lum;
        mul_next.opa   = sel_reg.opa;
        mul_next.neg   = d_s[D_W-1];
        mul_next.den   = d_abs[DEN_W-1:0];
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            c0_x = $signed(NUM_W'(sel_reg.c0[ch]));
            dc_x = NUM_W'($signed(sel_reg.dc[ch]));
            mul_next.a[ch] = c0_x * d_x;
            mul_next.b[ch] = dp_x * dc_x;
        end
    end

    // numerator, with the divisor's sign folded into it
    always_comb
    begin
        logic signed [NUM_W-1:0] sum;
        logic signed [NUM_W-1:0] mag_s;
        num_next.found = mul_reg.found;
        num_next.lum   = mul_reg.lum;
        num_next.opa   = mul_reg.opa;
        num_next.den   = mul_reg.den;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum   = $signed(mul_reg.a[ch]) + $signed(mul_reg.b[ch]);
            mag_s = mul_reg.neg ? -sum : sum;
            num_next.pos[ch] = !mag_s[NUM_W-1] && (mag_s != '0);
            num_next.mag[ch] = mag_s[MAG_W-1:0];
        end
    end

    // gain, Q2.8 fraction dropped before the divide
    always_comb
    begin
        logic [GAIN_W-1:0] gain;
        logic [PROD_W-1:0] prod;
        gain_next.found = num_reg.found;
        gain_next.den   = num_reg.den;
        gain_next.pos   = num_reg.pos;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            gain = (ch == CH_ALPHA) ? num_reg.opa : num_reg.lum;
            prod = PROD_W'(gain) * PROD_W'(num_reg.mag[ch]);
            gain_next.n[ch] = prod[PROD_W-1:GAIN_FRAC];
        end
    end

    // quotient of 256 or more saturates
    always_comb
    begin
        logic [N_W-1:0] lim;
        lim = N_W'({gain_reg.den, {QUO_W{1'b0}}});
        div_next[0].found = gain_reg.found;
        div_next[0].den   = gain_reg.den;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            div_next[0].lane[ch].pos = gain_reg.pos[ch];
            div_next[0].lane[ch].sat = gain_reg.n[ch] >= lim;
            div_next[0].lane[ch].rem = (gain_reg.n[ch] >= lim) ? '0
                                                                : gain_reg.n[ch][REM_W-1:0];
            div_next[0].lane[ch].quo = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_IN])   in_reg   <= in_next;
        if (adv[S_SEG])  seg_reg  <= seg_next;
        if (adv[S_SEL])  sel_reg  <= sel_next;
        if (adv[S_MUL])  mul_reg  <= mul_next;
        if (adv[S_NUM])  num_reg  <= num_next;
        if (adv[S_GAIN]) gain_reg <= gain_next;
        if (adv[S_DIV])  div_reg[0] <= div_next[0];
        if (adv[S_OUT])  out_reg  <= out_next;
    end

    // restoring divide, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        always_comb
        begin
            logic [REM_W-1:0] dsh;
            dsh = REM_W'(div_reg[j-1].den) << (QUO_W - j);
            div_next[j] = div_reg[j-1];
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (div_reg[j-1].lane[ch].rem >= dsh)
                begin
                    div_next[j].lane[ch].rem = div_reg[j-1].lane[ch].rem - dsh;
                    div_next[j].lane[ch].quo[QUO_W - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[S_DIV + j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // no segment: opaque black
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (!div_reg[DIV_STEPS].found)
            begin
                out_next[ch] = (ch == CH_ALPHA) ? CH_MAX : '0;
            end
            else if (!div_reg[DIV_STEPS].lane[ch].pos)
            begin
                out_next[ch] = '0;
            end
            else if (div_reg[DIV_STEPS].lane[ch].sat)
            begin
                out_next[ch] = CH_MAX;
            end
            else
            begin
                out_next[ch] = div_reg[DIV_STEPS].lane[ch].quo;
            end
        end
    end

    assign color.valid     = valid_reg[S_OUT];
    assign color.red       = out_reg[3];
    assign color.green     = out_reg[2];
    assign color.blue      = out_reg[1];
    assign color.alpha_out = out_reg[CH_ALPHA];

    `GCL_ASSERT_NEXT(a_accept_fills_entry, clk, rst_n, pixel.valid && pixel.ready, valid_reg[S_IN], "accepted request missing from entry stage")
    `GCL_ASSERT_SAME(a_bubble_gives_ready, clk, rst_n, !(&valid_reg), pixel.ready, "input stalled with an empty stage in the pipe")

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_chk
        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_lane
            `GCL_ASSERT_SAME(a_rem_bound, clk, rst_n, valid_reg[S_DIV + j], div_reg[j].lane[c].rem < (REM_W'(div_reg[j].den) << (QUO_W - j)), "divider remainder out of range")
        end
    end

endmodule
